>>> src/g2e_pkg.sv
// Shared types, constants and pipeline latencies for the geodetic to ENU converter.
`timescale 1ns / 1ps

package g2e_pkg;

	typedef logic signed [63:0] word_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} pos_t;

	typedef struct packed {
		word_t sl;
		word_t cl;
		word_t so;
		word_t co;
	} trig_t;

	localparam word_t PI_Q60   = 64'sh3243_F6A8_885A_308D;
	localparam word_t ONE_Q60  = 64'sd1 <<< 60;
	localparam word_t A_MM_Q16 = 64'sd6378137000 * 64'sd65536;

	// Ellipsoid axis ratio and first eccentricity squared, worked out at elaboration
	localparam logic [127:0] B_TENTH_MM = 128'd63567523142;
	localparam logic [127:0] A_TENTH_MM = 128'd63781370000;
	localparam logic [127:0] BA_Q60     = (B_TENTH_MM << 60) / A_TENTH_MM;
	localparam logic [127:0] Q2_FULL    = (BA_Q60 * BA_Q60) >> 60;
	localparam word_t        Q2_Q60     = word_t'(Q2_FULL[63:0]);
	localparam word_t        E2_Q60     = ONE_Q60 - Q2_Q60;

	localparam word_t OUT_MAX = (64'sd1 <<< 35) - 64'sd1;
	localparam word_t OUT_MIN = -(64'sd1 <<< 35);

	localparam int MUL_LAT      = 4;
	localparam int DIV_LAT      = 4;
	localparam int SC_TERMS     = 13;
	localparam int BIN_TERMS    = 10;
	localparam int SC_PRE_LAT   = 2 * MUL_LAT;
	localparam int SC_STEP_LAT  = MUL_LAT + DIV_LAT;
	localparam int SC_LAT       = SC_PRE_LAT + SC_TERMS * SC_STEP_LAT + 1;
	localparam int BIN_STEP_LAT = MUL_LAT + 1 + DIV_LAT;
	localparam int ECEF_POST    = 2 * MUL_LAT + BIN_TERMS * BIN_STEP_LAT + 3 * MUL_LAT;
	localparam int ECEF_LAT     = SC_LAT + ECEF_POST;
	localparam int ROT_LAT      = 2 * MUL_LAT + 1;
	localparam int TOTAL_LAT    = ECEF_LAT + 1 + ROT_LAT + 1;

endpackage

>>> src/g2e_mul.sv
// Pipelined signed 64x64 multiply, floor of the product over 2^60, clamped to 63 bits.
`timescale 1ns / 1ps

module g2e_mul (
	input  logic           clk,
	input  g2e_pkg::word_t a,
	input  g2e_pkg::word_t b,
	output g2e_pkg::word_t p
);

	logic [63:0]  ua_s1, ub_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] prod_s3;
	logic [127:0] sum;
	logic [64:0]  q65;
	logic         sat;
	logic [63:0]  qm;
	g2e_pkg::word_t p_s4;

	always_comb begin
		sum = 128'(p00_s2) + (128'(p01_s2) << 32) + (128'(p10_s2) << 32) + (128'(p11_s2) << 64);
		q65 = {1'b0, prod_s3[123:60]} + 65'(neg_s3 & (|prod_s3[59:0]));
		sat = (|prod_s3[127:124]) | (|q65[64:63]);
		qm  = sat ? 64'h7FFF_FFFF_FFFF_FFFF : q65[63:0];
	end

	always_ff @(posedge clk) begin
		// magnitudes and sign
		ua_s1   <= a[63] ? 64'(64'd0 - a) : 64'(a);
		ub_s1   <= b[63] ? 64'(64'd0 - b) : 64'(b);
		neg_s1  <= a[63] ^ b[63];
		// four partial products
		p00_s2  <= 64'(ua_s1[31:0]) * 64'(ub_s1[31:0]);
		p01_s2  <= 64'(ua_s1[31:0]) * 64'(ub_s1[63:32]);
		p10_s2  <= 64'(ua_s1[63:32]) * 64'(ub_s1[31:0]);
		p11_s2  <= 64'(ua_s1[63:32]) * 64'(ub_s1[63:32]);
		neg_s2  <= neg_s1;
		// full product
		prod_s3 <= sum;
		neg_s3  <= neg_s2;
		// shift, round towards minus infinity, clamp
		p_s4    <= neg_s3 ? g2e_pkg::word_t'(64'd0 - qm) : g2e_pkg::word_t'(qm);
	end

	assign p = p_s4;

endmodule

>>> src/g2e_divc.sv
// Pipelined unsigned 64-bit divide by a small constant through its reciprocal.
`timescale 1ns / 1ps

module g2e_divc (
	input  logic        clk,
	input  logic [63:0] m,
	input  logic [9:0]  d,
	input  logic [63:0] rcp,
	output logic [63:0] q
);

	logic [63:0]  m_s1, m_s2, m_s3;
	logic [63:0]  p00_s1, p01_s1, p10_s1, p11_s1;
	logic [63:0]  qe_s2, qe_s3;
	logic [63:0]  qd_s3;
	logic [63:0]  q_s4;
	logic [127:0] sum;
	logic [63:0]  r;

	always_comb begin
		sum = 128'(p00_s1) + (128'(p01_s1) << 32) + (128'(p10_s1) << 32) + (128'(p11_s1) << 64);
		r   = m_s3 - qd_s3;
	end

	always_ff @(posedge clk) begin
		p00_s1 <= 64'(m[31:0]) * 64'(rcp[31:0]);
		p01_s1 <= 64'(m[31:0]) * 64'(rcp[63:32]);
		p10_s1 <= 64'(m[63:32]) * 64'(rcp[31:0]);
		p11_s1 <= 64'(m[63:32]) * 64'(rcp[63:32]);
		m_s1   <= m;
		// estimate is the quotient or one short of it
		qe_s2  <= sum[127:64];
		m_s2   <= m_s1;
		qd_s3  <= qe_s2 * 64'(d);
		qe_s3  <= qe_s2;
		m_s3   <= m_s2;
		q_s4   <= qe_s3 + 64'(r >= 64'(d));
	end

	assign q = q_s4;

endmodule

>>> src/g2e_sincos.sv
// Pipelined sine and cosine in Q60 of a semicircle angle, Taylor series over 13 terms.
`timescale 1ns / 1ps

module g2e_sincos (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [31:0]    ang,
	output logic           out_valid,
	output g2e_pkg::word_t sn,
	output g2e_pkg::word_t cs
);

	localparam int NT   = g2e_pkg::SC_TERMS;
	localparam int PRE  = g2e_pkg::SC_PRE_LAT;
	localparam int STEP = g2e_pkg::SC_STEP_LAT;
	localparam int ML   = g2e_pkg::MUL_LAT;

	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

	typedef struct packed {
		logic  valid;
		quad_t quad;
	} pre_t;

	typedef struct packed {
		logic           valid;
		quad_t          quad;
		g2e_pkg::word_t x2;
		g2e_pkg::word_t s;
		g2e_pkg::word_t c;
	} step_t;

	pre_t           pre_q [PRE];
	g2e_pkg::word_t xd_q  [ML];
	g2e_pkg::word_t x, x2;

	g2e_pkg::word_t ts_o [NT+1];
	g2e_pkg::word_t tc_o [NT+1];
	g2e_pkg::word_t s_o  [NT+1];
	g2e_pkg::word_t c_o  [NT+1];
	g2e_pkg::word_t x2_o [NT+1];
	quad_t          quad_o [NT+1];
	logic           v_o  [NT+1];

	g2e_mul u_x (
		.clk (clk),
		.a   (g2e_pkg::word_t'({5'b0, ang[29:0], 29'b0})),
		.b   (g2e_pkg::PI_Q60),
		.p   (x)
	);

	g2e_mul u_x2 (
		.clk (clk),
		.a   (x),
		.b   (x),
		.p   (x2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRE; i++) pre_q[i] <= '0;
		end else begin
			pre_q[0] <= '{valid: in_valid, quad: quad_t'(ang[31:30])};
			for (int i = 1; i < PRE; i++) pre_q[i] <= pre_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		xd_q[0] <= x;
		for (int i = 1; i < ML; i++) xd_q[i] <= xd_q[i-1];
	end

	assign ts_o[0]   = xd_q[ML-1];
	assign tc_o[0]   = g2e_pkg::ONE_Q60;
	assign s_o[0]    = xd_q[ML-1];
	assign c_o[0]    = g2e_pkg::ONE_Q60;
	assign x2_o[0]   = x2;
	assign quad_o[0] = pre_q[PRE-1].quad;
	assign v_o[0]    = pre_q[PRE-1].valid;

	for (genvar k = 1; k <= NT; k++) begin : g_term
		localparam logic [9:0]  DS = 10'((2 * k) * (2 * k + 1));
		localparam logic [9:0]  DC = 10'((2 * k - 1) * (2 * k));
		localparam logic [64:0] RS = (65'd1 << 64) / 65'(DS);
		localparam logic [64:0] RC = (65'd1 << 64) / 65'(DC);

		g2e_pkg::word_t ms, mc;
		logic [63:0]    qs, qc;
		step_t          sp_q [STEP];

		g2e_mul u_ms (.clk(clk), .a(ts_o[k-1]), .b(x2_o[k-1]), .p(ms));
		g2e_mul u_mc (.clk(clk), .a(tc_o[k-1]), .b(x2_o[k-1]), .p(mc));
		g2e_divc u_ds (.clk(clk), .m(ms), .d(DS), .rcp(RS[63:0]), .q(qs));
		g2e_divc u_dc (.clk(clk), .m(mc), .d(DC), .rcp(RC[63:0]), .q(qc));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < STEP; i++) sp_q[i] <= '0;
			end else begin
				sp_q[0] <= '{valid: v_o[k-1], quad: quad_o[k-1], x2: x2_o[k-1],
					s: s_o[k-1], c: c_o[k-1]};
				for (int i = 1; i < STEP; i++) sp_q[i] <= sp_q[i-1];
			end
		end

		assign ts_o[k]   = qs;
		assign tc_o[k]   = qc;
		assign x2_o[k]   = sp_q[STEP-1].x2;
		assign quad_o[k] = sp_q[STEP-1].quad;
		assign v_o[k]    = sp_q[STEP-1].valid;

		// odd terms subtract, even terms add
		if (k % 2 == 1) begin : g_sub
			assign s_o[k] = sp_q[STEP-1].s - g2e_pkg::word_t'(qs);
			assign c_o[k] = sp_q[STEP-1].c - g2e_pkg::word_t'(qc);
		end else begin : g_add
			assign s_o[k] = sp_q[STEP-1].s + g2e_pkg::word_t'(qs);
			assign c_o[k] = sp_q[STEP-1].c + g2e_pkg::word_t'(qc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_o[NT];
		end
	end

	// fold the quadrant back in
	always_ff @(posedge clk) begin
		case (quad_o[NT])
			QUAD_0: begin
				sn <= s_o[NT];
				cs <= c_o[NT];
			end
			QUAD_1: begin
				sn <= c_o[NT];
				cs <= -s_o[NT];
			end
			QUAD_2: begin
				sn <= -s_o[NT];
				cs <= -c_o[NT];
			end
			QUAD_3: begin
				sn <= -c_o[NT];
				cs <= s_o[NT];
			end
		endcase
	end

endmodule

>>> src/g2e_ecef.sv
// Pipelined geodetic to earth-centred conversion, millimetres in Q16, with the trig terms.
`timescale 1ns / 1ps

module g2e_ecef (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [31:0]        lat,
	input  logic [31:0]        lon,
	input  logic signed [31:0] alt,
	output logic               out_valid,
	output g2e_pkg::pos_t      pos,
	output g2e_pkg::trig_t     trig
);

	localparam int SCL  = g2e_pkg::SC_LAT;
	localparam int POST = g2e_pkg::ECEF_POST;
	localparam int ML   = g2e_pkg::MUL_LAT;
	localparam int NB   = g2e_pkg::BIN_TERMS;
	localparam int BS   = g2e_pkg::BIN_STEP_LAT;
	// side data taps for the radius and the final products
	localparam int T3   = 2 * ML + NB * BS + ML - 1;
	localparam int T4   = T3 + ML;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] alt;
		g2e_pkg::trig_t     tr;
	} side_t;

	typedef struct packed {
		g2e_pkg::word_t u;
		g2e_pkg::word_t inv;
	} bin_t;

	logic               v_sc;
	g2e_pkg::word_t     sl, cl, so, co;
	logic signed [31:0] alt_q [SCL];
	side_t              sp_q  [POST];
	g2e_pkg::word_t     ss, u;
	g2e_pkg::word_t     term_o [NB+1];
	g2e_pkg::word_t     inv_o  [NB+1];
	g2e_pkg::word_t     u_o    [NB+1];
	g2e_pkg::word_t     n, nq, tcl;
	g2e_pkg::word_t     t_sum, z_sum;

	g2e_sincos u_sc_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.ang       (lat),
		.out_valid (v_sc),
		.sn        (sl),
		.cs        (cl)
	);

	g2e_sincos u_sc_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.ang       (lon),
		.out_valid (),
		.sn        (so),
		.cs        (co)
	);

	always_ff @(posedge clk) begin
		alt_q[0] <= alt;
		for (int i = 1; i < SCL; i++) alt_q[i] <= alt_q[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POST; i++) sp_q[i] <= '0;
		end else begin
			sp_q[0] <= '{valid: v_sc, alt: alt_q[SCL-1],
				tr: '{sl: sl, cl: cl, so: so, co: co}};
			for (int i = 1; i < POST; i++) sp_q[i] <= sp_q[i-1];
		end
	end

	// u = e2 * sin^2(lat)
	g2e_mul u_ss (.clk(clk), .a(sl), .b(sl), .p(ss));
	g2e_mul u_u (.clk(clk), .a(g2e_pkg::E2_Q60), .b(ss), .p(u));

	assign term_o[0] = g2e_pkg::ONE_Q60;
	assign inv_o[0]  = g2e_pkg::ONE_Q60;
	assign u_o[0]    = u;

	// binomial series for 1/sqrt(1-u)
	for (genvar k = 1; k <= NB; k++) begin : g_bin
		localparam logic [9:0]  D = 10'(2 * k);
		localparam logic [64:0] R = (65'd1 << 64) / 65'(D);

		g2e_pkg::word_t mo;
		logic [63:0]    tm_q;
		logic [63:0]    qt;
		bin_t           bp_q [BS];

		g2e_mul u_m (.clk(clk), .a(term_o[k-1]), .b(u_o[k-1]), .p(mo));

		always_ff @(posedge clk) begin
			tm_q <= mo * 64'(2 * k - 1);
			bp_q[0] <= '{u: u_o[k-1], inv: inv_o[k-1]};
			for (int i = 1; i < BS; i++) bp_q[i] <= bp_q[i-1];
		end

		g2e_divc u_d (.clk(clk), .m(tm_q), .d(D), .rcp(R[63:0]), .q(qt));

		assign term_o[k] = qt;
		assign inv_o[k]  = bp_q[BS-1].inv + g2e_pkg::word_t'(qt);
		assign u_o[k]    = bp_q[BS-1].u;
	end

	// prime-vertical radius
	g2e_mul u_n (.clk(clk), .a(g2e_pkg::A_MM_Q16), .b(inv_o[NB]), .p(n));

	assign t_sum = n + (g2e_pkg::word_t'(sp_q[T3].alt) <<< 16);
	assign z_sum = nq + (g2e_pkg::word_t'(sp_q[T4].alt) <<< 16);

	g2e_mul u_tcl (.clk(clk), .a(t_sum), .b(sp_q[T3].tr.cl), .p(tcl));
	g2e_mul u_nq (.clk(clk), .a(g2e_pkg::Q2_Q60), .b(n), .p(nq));
	g2e_mul u_px (.clk(clk), .a(tcl), .b(sp_q[T4].tr.co), .p(pos.x));
	g2e_mul u_py (.clk(clk), .a(tcl), .b(sp_q[T4].tr.so), .p(pos.y));
	g2e_mul u_pz (.clk(clk), .a(z_sum), .b(sp_q[T4].tr.sl), .p(pos.z));

	assign out_valid = sp_q[POST-1].valid;
	assign trig      = sp_q[POST-1].tr;

endmodule

>>> src/g2e_rot.sv
// Pipelined rotation of an earth-centred difference into east, north and up.
`timescale 1ns / 1ps

module g2e_rot (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  g2e_pkg::pos_t  d,
	input  g2e_pkg::trig_t tr,
	output logic           out_valid,
	output g2e_pkg::word_t e,
	output g2e_pkg::word_t n,
	output g2e_pkg::word_t u
);

	localparam int ML = g2e_pkg::MUL_LAT;

	typedef struct packed {
		logic           valid;
		g2e_pkg::word_t dx;
		g2e_pkg::word_t dy;
	} dd_t;

	typedef struct packed {
		logic           valid;
		g2e_pkg::word_t e;
		g2e_pkg::word_t n1;
		g2e_pkg::word_t u3;
	} rv_t;

	dd_t            dd_q [ML];
	rv_t            rv_q [ML];
	g2e_pkg::word_t e1, e2, n1, u3, csl, ssl, ccl, scl;
	g2e_pkg::word_t n2, n3, u1, u2;

	g2e_mul u_e1 (.clk(clk), .a(tr.co), .b(d.y), .p(e1));
	g2e_mul u_e2 (.clk(clk), .a(tr.so), .b(d.x), .p(e2));
	g2e_mul u_n1 (.clk(clk), .a(tr.cl), .b(d.z), .p(n1));
	g2e_mul u_u3 (.clk(clk), .a(tr.sl), .b(d.z), .p(u3));
	g2e_mul u_csl (.clk(clk), .a(tr.co), .b(tr.sl), .p(csl));
	g2e_mul u_ssl (.clk(clk), .a(tr.so), .b(tr.sl), .p(ssl));
	g2e_mul u_ccl (.clk(clk), .a(tr.co), .b(tr.cl), .p(ccl));
	g2e_mul u_scl (.clk(clk), .a(tr.so), .b(tr.cl), .p(scl));

	g2e_mul u_n2 (.clk(clk), .a(csl), .b(dd_q[ML-1].dx), .p(n2));
	g2e_mul u_n3 (.clk(clk), .a(ssl), .b(dd_q[ML-1].dy), .p(n3));
	g2e_mul u_u1 (.clk(clk), .a(ccl), .b(dd_q[ML-1].dx), .p(u1));
	g2e_mul u_u2 (.clk(clk), .a(scl), .b(dd_q[ML-1].dy), .p(u2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ML; i++) begin
				dd_q[i] <= '0;
				rv_q[i] <= '0;
			end
			out_valid <= 1'b0;
		end else begin
			dd_q[0] <= '{valid: in_valid, dx: d.x, dy: d.y};
			rv_q[0] <= '{valid: dd_q[ML-1].valid, e: e1 - e2, n1: n1, u3: u3};
			for (int i = 1; i < ML; i++) begin
				dd_q[i] <= dd_q[i-1];
				rv_q[i] <= rv_q[i-1];
			end
			out_valid <= rv_q[ML-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		e <= rv_q[ML-1].e;
		n <= rv_q[ML-1].n1 - n2 - n3;
		u <= u1 + u2 + rv_q[ML-1].u3;
	end

endmodule

>>> src/geodetic_to_enu_wgs84.sv
// Top level of the WGS84 geodetic to local east-north-up converter with its register port.
`timescale 1ns / 1ps

// Converts one point per clock from WGS84 latitude, longitude (semicircles, 2^31 = 180
// degrees) and height (mm) to east, north and up offsets in millimetres from a configured
// origin. Start a transaction by raising start; busy never rises, so a point is taken on
// every cycle that start is high. Each result appears on east_mm, north_mm, up_mm and
// clipped for exactly one cycle, marked by done, once its point has run through the pipeline;
// the receiver must take it then, as results cannot be held back. The latency is set by
// the chain of pipelined multipliers and constant dividers that evaluate the
// 13-term sine and cosine series and the 10-term radius series one term per unit. The
// origin runs through a second copy of the same pipeline beside every point, so write
// the origin registers only when no transaction is in flight. clipped flags a result in
// which any component was saturated to 36 bits.
module geodetic_to_enu_wgs84 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_latitude,
	input  logic signed [31:0] point_longitude,
	input  logic signed [31:0] point_altitude,
	output logic               done,
	output logic signed [35:0] east_mm,
	output logic signed [35:0] north_mm,
	output logic signed [35:0] up_mm,
	output logic               clipped,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int TOTAL_LAT = g2e_pkg::TOTAL_LAT;

	typedef enum logic [1:0] {REG_OLAT, REG_OLON, REG_OALT} reg_idx_t;

	logic signed [31:0] olat_q, olon_q, oalt_q;
	logic               wr_en;

	logic               pv;
	g2e_pkg::pos_t      pos_p, pos_o;
	g2e_pkg::trig_t     trig_o;

	logic               vld_s1;
	g2e_pkg::pos_t      d_s1;
	g2e_pkg::trig_t     trig_s1;

	logic               rv;
	g2e_pkg::word_t     re, rn, ru;
	logic [36:0]        fe, fn, fu;

	// Round half up to whole millimetres and clamp to 36 bits; top bit flags a clamp
	function automatic logic [36:0] finish_mm(input g2e_pkg::word_t v);
		g2e_pkg::word_t mm;
		logic           clip;
		begin
			mm   = (v + 64'sd32768) >>> 16;
			clip = 1'b0;
			if (mm > g2e_pkg::OUT_MAX) begin
				mm   = g2e_pkg::OUT_MAX;
				clip = 1'b1;
			end
			if (mm < g2e_pkg::OUT_MIN) begin
				mm   = g2e_pkg::OUT_MIN;
				clip = 1'b1;
			end
			return {clip, mm[35:0]};
		end
	endfunction

	// The pipeline never stalls, so accept a point on every cycle
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Register port: writes complete in the access phase, unknown addresses drop
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olat_q <= '0;
			olon_q <= '0;
			oalt_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_OLAT: olat_q <= pwdata;
				REG_OLON: olon_q <= pwdata;
				REG_OALT: oalt_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OLAT: prdata = olat_q;
			REG_OLON: prdata = olon_q;
			REG_OALT: prdata = oalt_q;
			default:  prdata = '0;
		endcase
	end

	// Point and origin run side by side through identical earth-centred pipelines
	g2e_ecef u_ecef_pt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.lat       (point_latitude),
		.lon       (point_longitude),
		.alt       (point_altitude),
		.out_valid (pv),
		.pos       (pos_p),
		.trig      ()
	);

	g2e_ecef u_ecef_org (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.lat       (olat_q),
		.lon       (olon_q),
		.alt       (oalt_q),
		.out_valid (),
		.pos       (pos_o),
		.trig      (trig_o)
	);

	// Difference of the two positions; carry the origin's trig terms alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= pv;
		end
	end

	always_ff @(posedge clk) begin
		d_s1.x  <= pos_p.x - pos_o.x;
		d_s1.y  <= pos_p.y - pos_o.y;
		d_s1.z  <= pos_p.z - pos_o.z;
		trig_s1 <= trig_o;
	end

	g2e_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.d         (d_s1),
		.tr        (trig_s1),
		.out_valid (rv),
		.e         (re),
		.n         (rn),
		.u         (ru)
	);

	assign fe = finish_mm(re);
	assign fn = finish_mm(rn);
	assign fu = finish_mm(ru);

	// Output register: strobe done for one cycle with each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= rv;
		end
	end

	always_ff @(posedge clk) begin
		east_mm  <= fe[35:0];
		north_mm <= fn[35:0];
		up_mm    <= fu[35:0];
		clipped  <= fe[36] | fn[36] | fu[36];
	end

	// Every accepted point yields its result after the fixed pipeline latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##TOTAL_LAT done)
		else $error("result missing after pipeline latency");

	// No result without a point taken the pipeline latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TOTAL_LAT))
		else $error("result without a matching point");

	// A clamp flag means some component sits at a bound
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |->
			(east_mm == 36'sh7_FFFF_FFFF || east_mm == 36'sh8_0000_0000 ||
			north_mm == 36'sh7_FFFF_FFFF || north_mm == 36'sh8_0000_0000 ||
			up_mm == 36'sh7_FFFF_FFFF || up_mm == 36'sh8_0000_0000))
		else $error("clipped set with no component at a bound");

endmodule

>>> test/tb.sv
// Self-checking testbench for the geodetic to ENU converter: directed and random origins and points.
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic signed [35:0] east;
		logic signed [35:0] north;
		logic signed [35:0] up;
		logic               clip;
	} enu_t;

	// Bit-exact fixed-point model of the converter plus the queue of results in flight
	class enu_scoreboard;
		bit [31:0] org_lat, org_lon, org_alt;
		enu_t      awaited[$];
		int        errors;
		longint    q2, e2;

		function new();
			bit [63:0] rem, r;
			rem = 0;
			r   = 0;
			// bit-serial b/a in Q60, one quotient bit per step
			for (int i = 0; i < 60; i++) begin
				rem = rem << 1;
				r   = r << 1;
				if (i == 0)
					rem = 64'd63567523142;
				if (rem >= 64'd63781370000) begin
					rem -= 64'd63781370000;
					r |= 1;
				end
				if (i == 0) begin
					rem = rem << 1;
					r   = r << 1;
					if (rem >= 64'd63781370000) begin
						rem -= 64'd63781370000;
						r |= 1;
					end
				end
			end
			q2 = mul_floor(longint'(r), longint'(r), 60);
			e2 = (64'sd1 <<< 60) - q2;
			errors = 0;
		endfunction

		// floor(a*b / 2^s) on a full 128-bit product, clamped to 63 bits of magnitude
		function longint mul_floor(longint a, longint b, int s);
			logic signed [127:0] sa, sb;
			logic [127:0] ua, ub, prod, q;
			bit neg, rem;
			sa   = a;
			sb   = b;
			neg  = (a < 0) != (b < 0);
			ua   = (sa < 0) ? -sa : sa;
			ub   = (sb < 0) ? -sb : sb;
			prod = ua * ub;
			q    = prod >> s;
			rem  = (prod & ((128'd1 << s) - 1)) != 0;
			if (neg && rem)
				q++;
			if (q > 128'h7FFF_FFFF_FFFF_FFFF)
				q = 128'h7FFF_FFFF_FFFF_FFFF;
			return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function void sin_cos(bit [31:0] ang, output longint sn, output longint cs);
			longint x, x2, ts, tc, s, c;
			x  = mul_floor(longint'({2'b00, ang[29:0]}), g2e_pkg::PI_Q60, 31);
			x2 = mul_floor(x, x, 60);
			ts = x;
			tc = g2e_pkg::ONE_Q60;
			s  = x;
			c  = g2e_pkg::ONE_Q60;
			for (longint k = 1; k <= 13; k++) begin
				ts = mul_floor(ts, x2, 60) / ((2 * k) * (2 * k + 1));
				tc = mul_floor(tc, x2, 60) / ((2 * k - 1) * (2 * k));
				if (k[0]) begin
					s -= ts;
					c -= tc;
				end else begin
					s += ts;
					c += tc;
				end
			end
			case (ang[31:30])
				2'd0: begin sn = s;  cs = c;  end
				2'd1: begin sn = c;  cs = -s; end
				2'd2: begin sn = -s; cs = -c; end
				default: begin sn = -c; cs = s; end
			endcase
		endfunction

		// earth-centred position in mm Q16, with the trig terms of the point
		function void geo_to_ecef(bit [31:0] lat, bit [31:0] lon, bit [31:0] alt,
				output longint px, output longint py, output longint pz,
				output longint sl, output longint cl, output longint so, output longint co);
			longint u, term, inv, n, h, t;
			sin_cos(lat, sl, cl);
			sin_cos(lon, so, co);
			u    = mul_floor(e2, mul_floor(sl, sl, 60), 60);
			term = g2e_pkg::ONE_Q60;
			inv  = g2e_pkg::ONE_Q60;
			for (longint k = 1; k <= 10; k++) begin
				term = mul_floor(term, u, 60) * (2 * k - 1) / (2 * k);
				inv += term;
			end
			n  = mul_floor(g2e_pkg::A_MM_Q16, inv, 60);
			h  = longint'(signed'(alt)) * 65536;
			t  = n + h;
			px = mul_floor(mul_floor(t, cl, 60), co, 60);
			py = mul_floor(mul_floor(t, cl, 60), so, 60);
			pz = mul_floor(mul_floor(q2, n, 60) + h, sl, 60);
		endfunction

		function logic signed [35:0] round_clamp(longint v, inout logic clip);
			longint mm;
			mm = (v + 32768) >>> 16;
			if (mm > g2e_pkg::OUT_MAX) begin
				clip = 1;
				mm   = g2e_pkg::OUT_MAX;
			end
			if (mm < g2e_pkg::OUT_MIN) begin
				clip = 1;
				mm   = g2e_pkg::OUT_MIN;
			end
			return mm[35:0];
		endfunction

		function void note_point(bit [31:0] lat, bit [31:0] lon, bit [31:0] alt);
			longint px, py, pz, ox, oy, oz, dx, dy, dz;
			longint sl, cl, so, co, t0, t1, t2, t3, e, nn, up;
			enu_t r;
			geo_to_ecef(lat, lon, alt, px, py, pz, t0, t1, t2, t3);
			geo_to_ecef(org_lat, org_lon, org_alt, ox, oy, oz, sl, cl, so, co);
			dx = px - ox;
			dy = py - oy;
			dz = pz - oz;
			e  = mul_floor(co, dy, 60) - mul_floor(so, dx, 60);
			nn = mul_floor(cl, dz, 60) - mul_floor(mul_floor(co, sl, 60), dx, 60)
				- mul_floor(mul_floor(so, sl, 60), dy, 60);
			up = mul_floor(mul_floor(co, cl, 60), dx, 60)
				+ mul_floor(mul_floor(so, cl, 60), dy, 60) + mul_floor(sl, dz, 60);
			r.clip  = 0;
			r.east  = round_clamp(e, r.clip);
			r.north = round_clamp(nn, r.clip);
			r.up    = round_clamp(up, r.clip);
			awaited.push_back(r);
		endfunction

		function void check_result(logic signed [35:0] east, logic signed [35:0] north,
				logic signed [35:0] up, logic clip);
			enu_t r;
			if (awaited.size() == 0) begin
				$error("unexpected result east=%0d north=%0d up=%0d", east, north, up);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (east !== r.east) begin
				$error("east_mm: expected %0d, got %0d", r.east, east);
				errors++;
			end
			if (north !== r.north) begin
				$error("north_mm: expected %0d, got %0d", r.north, north);
				errors++;
			end
			if (up !== r.up) begin
				$error("up_mm: expected %0d, got %0d", r.up, up);
				errors++;
			end
			if (clip !== r.clip) begin
				$error("clipped: expected %0b, got %0b", r.clip, clip);
				errors++;
			end
		endfunction
	endclass

	localparam logic [3:0] ADDR_LAT  = 4'd0;
	localparam logic [3:0] ADDR_LON  = 4'd4;
	localparam logic [3:0] ADDR_ALT  = 4'd8;
	localparam logic [3:0] ADDR_NONE = 4'd12;
	localparam int         IDLE_LIMIT = 4000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] point_latitude;
	logic signed [31:0] point_longitude;
	logic signed [31:0] point_altitude;
	logic               done;
	logic signed [35:0] east_mm;
	logic signed [35:0] north_mm;
	logic signed [35:0] up_mm;
	logic               clipped;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	enu_scoreboard sb;
	int            idle_cycles;
	bit            zero_gaps;

	geodetic_to_enu_wgs84 uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point_latitude(point_latitude),
		.point_longitude(point_longitude),
		.point_altitude(point_altitude),
		.done(done),
		.east_mm(east_mm),
		.north_mm(north_mm),
		.up_mm(up_mm),
		.clipped(clipped),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Check every strobed result; the receiver has no way to stall, so sample each edge
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(east_mm, north_mm, up_mm, clipped);
	end

	// Watchdog: count edges with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Register write over the APB port: setup cycle, then access until pready
	task automatic reg_write(logic [3:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_LAT)
			sb.org_lat = data;
		else if (addr == ADDR_LON)
			sb.org_lon = data;
		else if (addr == ADDR_ALT)
			sb.org_alt = data;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// hold the bus idle before the next access
		@(posedge clk);
	endtask

	// Present one point, after a random gap unless gaps are off, and hold it until the block takes it
	task automatic send_point(logic [31:0] lat, logic [31:0] lon, logic [31:0] alt);
		int gap;
		gap = zero_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		point_latitude  <= lat;
		point_longitude <= lon;
		point_altitude  <= alt;
		do @(posedge clk); while (busy);
		sb.note_point(lat, lon, alt);
	endtask

	// Drop start and hold until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		while (sb.awaited.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_origin(logic [31:0] lat, logic [31:0] lon, logic [31:0] alt);
		drain();
		reg_write(ADDR_ALT, alt);
		reg_write(ADDR_LON, lon);
		reg_write(ADDR_LAT, lat);
	endtask

	// Latitude mostly within +-90 degrees, now and then any bit pattern
	function automatic logic [31:0] rand_lat();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
	endfunction

	function automatic logic [31:0] rand_alt();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 20_000_000) - 10_000_000;
			default: return $urandom_range(0, 2_000_000) - 1_000_000;
		endcase
	endfunction

	initial begin
		logic [31:0] dir_lat[] = '{32'h4000_0000, 32'hC000_0000, 32'h0, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h3FFF_FFFF, 32'hC000_0001, 32'h2000_0000};
		logic [31:0] dir_lon[] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h4000_0000,
			32'hC000_0000, 32'hFFFF_FFFF};
		logic [31:0] dir_alt[] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
		logic [31:0] org_lat[] = '{32'h4000_0000, 32'hC000_0000, 32'h8000_0000,
			32'h1555_5555};
		logic [31:0] org_lon[] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hE000_0000};
		logic [31:0] org_alt[] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_86A0};

		sb              = new();
		arst_n          = 1'b0;
		start           = 1'b0;
		point_latitude  = '0;
		point_longitude = '0;
		point_altitude  = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		idle_cycles     = 0;
		zero_gaps       = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points against the reset origin: field extremes and wrapped latitudes
		for (int i = 0; i < dir_lat.size(); i++)
			send_point(dir_lat[i], dir_lon[i % dir_lon.size()], dir_alt[i % dir_alt.size()]);
		for (int i = 0; i < dir_alt.size(); i++)
			send_point(32'h0, dir_lon[i], dir_alt[i]);
		// South pole at maximum height, a case for saturation
		send_point(32'hC000_0000, 32'h0, 32'h7FFF_FFFF);

		// A write to an address past the register list must change nothing
		drain();
		reg_write(ADDR_NONE, $urandom);
		send_point(32'h1000_0000, 32'h2000_0000, 32'd1000);
		send_point(32'hC000_0000, 32'h8000_0000, 32'h8000_0000);

		// Phases: extreme origins first, then random ones
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < org_lat.size())
				set_origin(org_lat[ph], org_lon[ph], org_alt[ph]);
			else
				set_origin(rand_lat(), $urandom, rand_alt());
			for (int i = 0; i < 145; i++) begin
				// every 40 points, pick at random between bursts with no idling and bursts with random gaps
				if (i % 40 == 0)
					zero_gaps = ($urandom_range(0, 2) == 0);
				if ($urandom_range(0, 7) == 0)
					send_point(sb.org_lat + $urandom_range(0, 2000) - 1000,
						sb.org_lon + $urandom_range(0, 2000) - 1000,
						sb.org_alt + $urandom_range(0, 2000) - 1000);
				else
					send_point(rand_lat(), $urandom, rand_alt());
			end
		end

		drain();
		repeat (g2e_pkg::TOTAL_LAT + 20) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
